FILE: src/sat_pkg.sv
`timescale 1ns / 1ps

package sat_pkg;

  // Item opcodes
  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_V2F  = 2'd1,
    OP_F2V  = 2'd2
  } op_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_HEADER_SIZE   = 2'd0,
    REG_ALIGN_SHIFT   = 2'd1,
    REG_SECTION_COUNT = 2'd2
  } cfg_reg_t;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned SHIFT_W  = 5;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned EIDX_W   = 4;
  localparam int unsigned CIDX_W   = 2;
  localparam logic [SHIFT_W-1:0] ALIGN_SHIFT_RST = 5'd12;

  // Lookup word travelling down the pipeline
  typedef struct packed {
    logic              rev;   // file offset to virtual address
    logic              pass;  // at or below the header size
    logic [ADDR_W-1:0] addr;
  } item_t;

endpackage

FILE: src/sat_in_if.sv
`timescale 1ns / 1ps

interface sat_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      opcode;
  logic [sat_pkg::EIDX_W-1:0]      entry_index;
  logic [sat_pkg::ADDR_W-1:0]      virt_base;
  logic [sat_pkg::ADDR_W-1:0]      raw_size;
  logic [sat_pkg::ADDR_W-1:0]      raw_offset;
  logic [sat_pkg::ADDR_W-1:0]      address;

  modport source (
    output valid, opcode, entry_index, virt_base, raw_size, raw_offset, address,
    input  ready
  );
  modport sink (
    input  valid, opcode, entry_index, virt_base, raw_size, raw_offset, address,
    output ready
  );
endinterface

FILE: src/sat_out_if.sv
`timescale 1ns / 1ps

interface sat_out_if;
  logic                       valid;
  logic                       ready;
  logic [sat_pkg::ADDR_W-1:0] translated;
  logic                       found;

  modport source (output valid, translated, found, input ready);
  modport sink (input valid, translated, found, output ready);
endinterface

FILE: src/sat_table.sv
`timescale 1ns / 1ps

// Section entries with one range comparator per entry and one read port
module sat_table #(
  parameter int unsigned N  = 16,
  parameter int unsigned IW = (N > 1) ? $clog2(N) : 1
) (
  input  logic                           clk,
  // entry load
  input  logic                           wr_en,
  input  logic [sat_pkg::EIDX_W-1:0]     wr_idx,
  input  logic [sat_pkg::ADDR_W-1:0]     wr_virt_base,
  input  logic [sat_pkg::ADDR_W-1:0]     wr_raw_size,
  input  logic [sat_pkg::ADDR_W-1:0]     wr_raw_offset,
  // range compare
  input  logic                           cmp_rev,
  input  logic [sat_pkg::ADDR_W-1:0]     cmp_addr,
  input  logic [sat_pkg::ADDR_W-1:0]     cmp_low_mask,
  input  logic [sat_pkg::COUNT_W-1:0]    cmp_count,
  output logic [N-1:0]                   cmp_hit,
  // read of the matched entry
  input  logic [IW-1:0]                  rd_idx,
  input  logic                           rd_rev,
  output logic [sat_pkg::ADDR_W-1:0]     rd_base,
  output logic [sat_pkg::ADDR_W-1:0]     rd_other
);

  logic [sat_pkg::ADDR_W-1:0] vb_r  [N];
  logic [sat_pkg::ADDR_W-1:0] sz_r  [N];
  logic [sat_pkg::ADDR_W-1:0] off_r [N];

  for (genvar i = 0; i < N; i++) begin : g_lane
    logic [sat_pkg::ADDR_W-1:0] base;
    logic [sat_pkg::ADDR_W-1:0] size;
    logic [sat_pkg::ADDR_W-1:0] lim;
    logic                       en;

    // load the entry when its index is addressed
    always_ff @(posedge clk) begin
      if (wr_en && (32'(wr_idx) == 32'(i))) begin
        vb_r[i]  <= wr_virt_base;
        sz_r[i]  <= wr_raw_size;
        off_r[i] <= wr_raw_offset;
      end
    end

    // virtual ranges use the aligned size, file ranges the raw size
    always_comb begin
      base = cmp_rev ? off_r[i] : vb_r[i];
      size = cmp_rev ? sz_r[i] : ((sz_r[i] + cmp_low_mask) & ~cmp_low_mask);
      lim  = base + size;
      en   = 32'(cmp_count) > 32'(i);
      cmp_hit[i] = en && (cmp_addr >= base) && (cmp_addr < lim);
    end
  end

  // fetch base and target of the first matching entry
  assign rd_base  = rd_rev ? off_r[rd_idx] : vb_r[rd_idx];
  assign rd_other = rd_rev ? vb_r[rd_idx] : off_r[rd_idx];

endmodule

FILE: src/sat_prio.sv
`timescale 1ns / 1ps

// First-match priority encoder over the entry hit vector
module sat_prio #(
  parameter int unsigned N  = 16,
  parameter int unsigned IW = (N > 1) ? $clog2(N) : 1
) (
  input  logic [N-1:0]  hits,
  output logic [IW-1:0] idx,
  output logic          any
);

  // lowest set bit wins
  always_comb begin
    idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (hits[i]) idx = IW'(i);
    end
    any = |hits;
  end

endmodule

FILE: src/section_address_translator.sv
`timescale 1ns / 1ps

// Section address translator. Load words (opcode 0) write one section entry and
// give no result; lookup words (opcode 1 virtual to file offset, opcode 2 file
// offset to virtual) each give one result word, in order. A lookup passes range
// compare against every entry in parallel, first-match encode, then entry read
// and offset arithmetic into the output register. One lookup is taken per cycle
// unless the output stalls; a load directly behind a lookup waits until that
// lookup has left the compare stage, so it reads the entry as it stood when
// it arrived. Entries read before loading give undefined results. Write
// configuration only while no lookup is in flight; the block does not check it.
module section_address_translator #(
  parameter int unsigned MAX_SECTIONS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  sat_in_if.sink                          in_ch,
  sat_out_if.source                       out_ch,
  input  logic                            cfg_wr_en,
  input  logic [sat_pkg::CIDX_W-1:0]      cfg_index,
  input  logic [sat_pkg::ADDR_W-1:0]      cfg_wdata
);

  localparam int unsigned IW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

  logic [sat_pkg::ADDR_W-1:0]  header_size_r;
  logic [sat_pkg::SHIFT_W-1:0] align_shift_r;
  logic [sat_pkg::COUNT_W-1:0] section_count_r;
  logic [sat_pkg::COUNT_W-1:0] count_lim;
  logic [sat_pkg::ADDR_W-1:0]  low_mask;

  logic                        adv;
  logic                        in_acc;
  logic                        is_load;
  logic                        is_lookup;
  sat_pkg::item_t              in_item;
  logic [MAX_SECTIONS-1:0]     hit_vec;

  logic                        s1_vld_r;
  sat_pkg::item_t              s1_item_r;
  logic [MAX_SECTIONS-1:0]     s1_hit_r;

  logic                        s2_vld_r;
  sat_pkg::item_t              s2_item_r;
  logic [IW-1:0]               s2_idx_r;
  logic                        s2_any_r;
  logic [IW-1:0]               pr_idx;
  logic                        pr_any;

  logic [sat_pkg::ADDR_W-1:0]  rd_base;
  logic [sat_pkg::ADDR_W-1:0]  rd_other;
  logic                        out_vld_r;
  logic [sat_pkg::ADDR_W-1:0]  out_xlat_r;
  logic [sat_pkg::ADDR_W-1:0]  out_xlat_nxt;
  logic                        out_found_r;
  logic                        out_found_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_size_r   <= '0;
      align_shift_r   <= sat_pkg::ALIGN_SHIFT_RST;
      section_count_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        sat_pkg::REG_HEADER_SIZE:   header_size_r   <= cfg_wdata;
        sat_pkg::REG_ALIGN_SHIFT:   align_shift_r   <= cfg_wdata[sat_pkg::SHIFT_W-1:0];
        sat_pkg::REG_SECTION_COUNT: section_count_r <= cfg_wdata[sat_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the searched count and form the alignment mask
  assign count_lim = (32'(section_count_r) > MAX_SECTIONS) ?
                     sat_pkg::COUNT_W'(MAX_SECTIONS) : section_count_r;
  assign low_mask  = ~({sat_pkg::ADDR_W{1'b1}} << align_shift_r);

  // advance the whole pipeline when the output register is free or taken
  assign adv          = !out_vld_r || out_ch.ready;
  assign in_ch.ready  = adv && !(s1_vld_r && (in_ch.opcode == sat_pkg::OP_LOAD));
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign is_load      = in_acc && (in_ch.opcode == sat_pkg::OP_LOAD);
  assign is_lookup    = in_acc && ((in_ch.opcode == sat_pkg::OP_V2F) ||
                                   (in_ch.opcode == sat_pkg::OP_F2V));
  assign in_item.rev  = (in_ch.opcode == sat_pkg::OP_F2V);
  assign in_item.pass = (in_ch.address <= header_size_r);
  assign in_item.addr = in_ch.address;

  sat_table #(.N(MAX_SECTIONS), .IW(IW)) u_table (
    .clk           (clk),
    .wr_en         (is_load),
    .wr_idx        (in_ch.entry_index),
    .wr_virt_base  (in_ch.virt_base),
    .wr_raw_size   (in_ch.raw_size),
    .wr_raw_offset (in_ch.raw_offset),
    .cmp_rev       (in_item.rev),
    .cmp_addr      (in_ch.address),
    .cmp_low_mask  (low_mask),
    .cmp_count     (count_lim),
    .cmp_hit       (hit_vec),
    .rd_idx        (s2_idx_r),
    .rd_rev        (s2_item_r.rev),
    .rd_base       (rd_base),
    .rd_other      (rd_other)
  );

  sat_prio #(.N(MAX_SECTIONS), .IW(IW)) u_prio (
    .hits (s1_hit_r),
    .idx  (pr_idx),
    .any  (pr_any)
  );

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= is_lookup;
      s2_vld_r  <= s1_vld_r;
      out_vld_r <= s2_vld_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r   <= in_item;
      s1_hit_r    <= hit_vec;
      s2_item_r   <= s1_item_r;
      s2_idx_r    <= pr_idx;
      s2_any_r    <= pr_any;
      out_xlat_r  <= out_xlat_nxt;
      out_found_r <= out_found_nxt;
    end
  end

  // pass through, relocate by the matched entry, or report a miss
  always_comb begin
    if (s2_item_r.pass) begin
      out_xlat_nxt  = s2_item_r.addr;
      out_found_nxt = 1'b1;
    end else if (s2_any_r) begin
      out_xlat_nxt  = s2_item_r.addr - rd_base + rd_other;
      out_found_nxt = 1'b1;
    end else begin
      out_xlat_nxt  = '0;
      out_found_nxt = 1'b0;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.translated = out_xlat_r;
  assign out_ch.found      = out_found_r;

  // a new result word only ever follows a lookup in the encode stage
  a_out_from_s2: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(s2_vld_r))
    else $error("result word appeared without a lookup behind it");

  // a load never overtakes a lookup still due to read the table
  a_load_order: assert property (@(posedge clk) disable iff (!rst_n)
    is_load |-> !s1_vld_r)
    else $error("load accepted while a lookup awaits its table read");

  // a miss always carries a zero address
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_found_r) |-> (out_xlat_r == '0))
    else $error("miss reported with non-zero address");

  // a match in the encode stage comes from a hit in the compare stage
  a_hit_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_vld_r && !s1_item_r.pass && (s1_hit_r == '0)) |=>
      (s2_vld_r && !s2_any_r))
    else $error("match flagged without a compare hit");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam logic [1:0] OP_UNUSED     = 2'd3;
  localparam int unsigned TABLE_DEPTH  = 16;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASE_WORDS  = 140;
  localparam int unsigned RANDOM_PHASES = 12;

  typedef struct packed {
    logic [1:0]                 opcode;
    logic [sat_pkg::EIDX_W-1:0] entry_index;
    logic [sat_pkg::ADDR_W-1:0] virt_base;
    logic [sat_pkg::ADDR_W-1:0] raw_size;
    logic [sat_pkg::ADDR_W-1:0] raw_offset;
    logic [sat_pkg::ADDR_W-1:0] address;
  } word_t;

  typedef struct packed {
    logic [sat_pkg::ADDR_W-1:0] translated;
    logic                       found;
  } xlat_t;

  logic clk;
  logic rst_n;
  logic                       cfg_wr_en;
  logic [sat_pkg::CIDX_W-1:0] cfg_index;
  logic [sat_pkg::ADDR_W-1:0] cfg_wdata;

  sat_in_if  in_ch ();
  sat_out_if out_ch ();

  section_address_translator #(.MAX_SECTIONS(TABLE_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the section table and registers
  logic [sat_pkg::ADDR_W-1:0]  sect_base_mem [TABLE_DEPTH];
  logic [sat_pkg::ADDR_W-1:0]  sect_size_mem [TABLE_DEPTH];
  logic [sat_pkg::ADDR_W-1:0]  sect_off_mem  [TABLE_DEPTH];
  logic [sat_pkg::ADDR_W-1:0]  hdr_size_q;
  logic [sat_pkg::SHIFT_W-1:0] align_q;
  logic [sat_pkg::COUNT_W-1:0] count_q;

  xlat_t pending_xlats [$];

  int errors;
  int mismatches;
  int loads_sent;
  int lookups_sent;
  int hits_seen;
  int passes_seen;
  int phases_run;
  int burst_left;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Generous run limit
  initial begin
    #2000000;
    $display("section_address_translator: mismatch");
    $finish;
  end

  function automatic logic [sat_pkg::ADDR_W-1:0] round_to_align(
      input logic [sat_pkg::ADDR_W-1:0] x);
    logic [63:0] low;
    logic [63:0] sum;
    low = (64'd1 << align_q) - 64'd1;
    sum = ({32'd0, x} + low) & ~low;
    return sum[sat_pkg::ADDR_W-1:0];
  endfunction

  function automatic int unsigned searched_entries();
    return (count_q > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_q);
  endfunction

  // Expected translation of one lookup word, first matching section wins
  function automatic xlat_t translate_address(input logic [1:0] op,
                                              input logic [sat_pkg::ADDR_W-1:0] addr);
    xlat_t r;
    logic [sat_pkg::ADDR_W-1:0] base;
    logic [sat_pkg::ADDR_W-1:0] size;
    logic [sat_pkg::ADDR_W-1:0] limit;
    logic [sat_pkg::ADDR_W-1:0] other;
    r = '0;
    if (addr <= hdr_size_q) begin
      r.translated = addr;
      r.found = 1'b1;
      return r;
    end
    for (int i = 0; i < int'(searched_entries()); i++) begin
      if (op == sat_pkg::OP_V2F) begin
        base  = sect_base_mem[sat_pkg::EIDX_W'(i)];
        size  = round_to_align(sect_size_mem[sat_pkg::EIDX_W'(i)]);
        other = sect_off_mem[sat_pkg::EIDX_W'(i)];
      end else begin
        base  = sect_off_mem[sat_pkg::EIDX_W'(i)];
        size  = sect_size_mem[sat_pkg::EIDX_W'(i)];
        other = sect_base_mem[sat_pkg::EIDX_W'(i)];
      end
      limit = base + size;
      if (addr >= base && addr < limit) begin
        r.translated = addr - base + other;
        r.found = 1'b1;
        return r;
      end
    end
    return r;
  endfunction

  function automatic word_t make_word(input logic [1:0] op,
                                      input logic [sat_pkg::EIDX_W-1:0] idx,
                                      input logic [sat_pkg::ADDR_W-1:0] vb,
                                      input logic [sat_pkg::ADDR_W-1:0] rs,
                                      input logic [sat_pkg::ADDR_W-1:0] ro,
                                      input logic [sat_pkg::ADDR_W-1:0] addr);
    word_t w;
    w.opcode      = op;
    w.entry_index = idx;
    w.virt_base   = vb;
    w.raw_size    = rs;
    w.raw_offset  = ro;
    w.address     = addr;
    return w;
  endfunction

  // Lookup word with random content in the fields it does not use
  function automatic word_t lookup_word(input logic [1:0] op,
                                        input logic [sat_pkg::ADDR_W-1:0] addr);
    return make_word(op, sat_pkg::EIDX_W'($urandom), $urandom, $urandom, $urandom, addr);
  endfunction

  // Send one word in bursts with random gaps, then update the shadow model
  task automatic send_word(input word_t w);
    int gap;
    xlat_t r;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 24);
    end
    @(negedge clk);
    in_ch.opcode      = w.opcode;
    in_ch.entry_index = w.entry_index;
    in_ch.virt_base   = w.virt_base;
    in_ch.raw_size    = w.raw_size;
    in_ch.raw_offset  = w.raw_offset;
    in_ch.address     = w.address;
    in_ch.valid       = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    if (w.opcode == sat_pkg::OP_LOAD) begin
      sect_base_mem[w.entry_index] = w.virt_base;
      sect_size_mem[w.entry_index] = w.raw_size;
      sect_off_mem[w.entry_index]  = w.raw_offset;
      loads_sent++;
    end else if (w.opcode != OP_UNUSED) begin
      r = translate_address(w.opcode, w.address);
      pending_xlats.push_back(r);
      lookups_sent++;
      if (r.found && w.address <= hdr_size_q) passes_seen++;
      else if (r.found) hits_seen++;
    end
  endtask

  // Drop valid, wait for every result and let the pipeline settle
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    burst_left = 0;
    while (pending_xlats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input sat_pkg::cfg_reg_t idx,
                           input logic [sat_pkg::ADDR_W-1:0] value);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      sat_pkg::REG_HEADER_SIZE:   hdr_size_q = value;
      sat_pkg::REG_ALIGN_SHIFT:   align_q    = value[sat_pkg::SHIFT_W-1:0];
      sat_pkg::REG_SECTION_COUNT: count_q    = value[sat_pkg::COUNT_W-1:0];
      default: ;
    endcase
  endtask

  // Receiver stalls, switching at random among four ready patterns
  initial begin
    int mode;
    int mode_left;
    int tick;
    mode = 0;
    mode_left = 0;
    tick = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(8, 80);
      end
      mode_left--;
      tick++;
      case (mode)
        0: out_ch.ready = 1'b1;
        1: out_ch.ready = 1'($urandom_range(0, 1));
        2: out_ch.ready = ($urandom_range(0, 3) == 0);
        default: out_ch.ready = tick[1];
      endcase
    end
  end

  // Compare each result word with the oldest pending translation
  always @(posedge clk) begin
    xlat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_xlats.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: translated %h found %b",
                   out_ch.translated, out_ch.found);
      end else begin
        want = pending_xlats.pop_front();
        if (out_ch.translated !== want.translated || out_ch.found !== want.found) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected translated %h found %b, got %h found %b",
                     want.translated, want.found, out_ch.translated, out_ch.found);
        end
      end
    end
  end

  // Small fixed table: overlaps, a wrapping section, raw size below alignment
  task automatic test_load_table();
    send_word(make_word(sat_pkg::OP_LOAD, 4'd0, 32'h0000_1000, 32'h0000_0200,
                        32'h0000_0400, $urandom));
    send_word(make_word(sat_pkg::OP_LOAD, 4'd1, 32'h0000_3000, 32'h0000_1800,
                        32'h0000_0600, $urandom));
    send_word(make_word(sat_pkg::OP_LOAD, 4'd2, 32'hFFFF_F000, 32'h0000_0800,
                        32'hFFFF_F800, $urandom));
    send_word(make_word(sat_pkg::OP_LOAD, 4'd3, 32'h0000_1800, 32'h0000_0100,
                        32'h0000_0500, $urandom));
    // nothing searched yet: a miss
    send_word(lookup_word(sat_pkg::OP_V2F, 32'h0000_1000));
    drain();
    write_reg(sat_pkg::REG_HEADER_SIZE, 32'h0000_03FF);
    write_reg(sat_pkg::REG_SECTION_COUNT, 32'd4);
  endtask

  task automatic test_header_passthrough();
    send_word(lookup_word(sat_pkg::OP_V2F, 32'h0000_0000));
    send_word(lookup_word(sat_pkg::OP_V2F, 32'h0000_03FF));
    send_word(lookup_word(sat_pkg::OP_F2V, 32'h0000_03FF));
    send_word(lookup_word(sat_pkg::OP_V2F, 32'h0000_0400));
    drain();
    write_reg(sat_pkg::REG_HEADER_SIZE, 32'hFFFF_FFFF);
    send_word(lookup_word(sat_pkg::OP_F2V, 32'hFFFF_FFFF));
    drain();
    write_reg(sat_pkg::REG_HEADER_SIZE, 32'h0000_03FF);
  endtask

  task automatic test_forward_lookup();
    send_word(lookup_word(sat_pkg::OP_V2F, 32'h0000_1000));
    send_word(lookup_word(sat_pkg::OP_V2F, 32'h0000_1FFF));
    send_word(lookup_word(sat_pkg::OP_V2F, 32'h0000_2000));
    send_word(lookup_word(sat_pkg::OP_V2F, 32'h0000_4FFF));
    send_word(lookup_word(sat_pkg::OP_V2F, 32'hFFFF_F800));
    send_word(lookup_word(sat_pkg::OP_V2F, 32'h0000_1850));
  endtask

  task automatic test_reverse_lookup();
    send_word(lookup_word(sat_pkg::OP_F2V, 32'h0000_05FF));
    send_word(lookup_word(sat_pkg::OP_F2V, 32'h0000_1DFF));
    send_word(lookup_word(sat_pkg::OP_F2V, 32'h0000_1E00));
    send_word(lookup_word(sat_pkg::OP_F2V, 32'h0000_0550));
  endtask

  task automatic test_alignment_rounding();
    drain();
    write_reg(sat_pkg::REG_ALIGN_SHIFT, 32'd0);
    send_word(lookup_word(sat_pkg::OP_V2F, 32'h0000_11FF));
    send_word(lookup_word(sat_pkg::OP_V2F, 32'h0000_1200));
    drain();
    write_reg(sat_pkg::REG_ALIGN_SHIFT, 32'd31);
    send_word(lookup_word(sat_pkg::OP_V2F, 32'h7000_0000));
    drain();
    write_reg(sat_pkg::REG_ALIGN_SHIFT, 32'd12);
  endtask

  task automatic test_unused_opcode();
    send_word(make_word(OP_UNUSED, 4'hF, $urandom, $urandom, $urandom, 32'h0000_1000));
    send_word(lookup_word(sat_pkg::OP_V2F, 32'h0000_1000));
  endtask

  function automatic logic [sat_pkg::ADDR_W-1:0] random_span();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return $urandom & ((32'd1 << $urandom_range(0, 20)) - 32'd1);
    if (sel < 9) return $urandom;
    return '0;
  endfunction

  // Clustered bases make overlapping sections common
  function automatic logic [sat_pkg::ADDR_W-1:0] random_base();
    if ($urandom_range(0, 1) == 0) return sat_pkg::ADDR_W'($urandom_range(0, 63)) << 12;
    return $urandom;
  endfunction

  function automatic word_t random_load(input logic [sat_pkg::EIDX_W-1:0] idx);
    return make_word(sat_pkg::OP_LOAD, idx, random_base(), random_span(), random_base(),
                     $urandom);
  endfunction

  // Address inside, on the edge of, or near a live section or the header
  function automatic logic [sat_pkg::ADDR_W-1:0] pick_address(input logic [1:0] op);
    int unsigned n;
    logic [sat_pkg::EIDX_W-1:0] i;
    int sel;
    logic [sat_pkg::ADDR_W-1:0] base;
    logic [sat_pkg::ADDR_W-1:0] size;
    n = searched_entries();
    i = sat_pkg::EIDX_W'((n == 0) ? $urandom_range(0, TABLE_DEPTH - 1) :
                                    $urandom_range(0, n - 1));
    if (op == sat_pkg::OP_V2F) begin
      base = sect_base_mem[i];
      size = round_to_align(sect_size_mem[i]);
    end else begin
      base = sect_off_mem[i];
      size = sect_size_mem[i];
    end
    sel = $urandom_range(0, 99);
    if (sel < 55) return (size == 0) ? base : base + $urandom_range(size - 1, 0);
    if (sel < 70) begin
      case ($urandom_range(0, 3))
        0: return base - 32'd1;
        1: return base;
        2: return base + size - 32'd1;
        default: return base + size;
      endcase
    end
    if (sel < 82) return hdr_size_q + sat_pkg::ADDR_W'($urandom_range(0, 1));
    return $urandom;
  endfunction

  // Fill the whole table before any wider search
  task automatic test_random_table();
    for (int i = 0; i < TABLE_DEPTH; i++) send_word(random_load(sat_pkg::EIDX_W'(i)));
  endtask

  task automatic test_random_phases();
    logic [sat_pkg::ADDR_W-1:0] h;
    logic [sat_pkg::ADDR_W-1:0] s;
    logic [sat_pkg::ADDR_W-1:0] c;
    int counted;
    int r;
    logic [1:0] op;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      case (phase)
        0: begin h = '0; s = 32'd0; c = 32'd16; end
        1: begin h = 32'hFFFF_FFFF; s = 32'd31; c = 32'd31; end
        2: begin h = '0; s = 32'd31; c = 32'd0; end
        default: begin
          case ($urandom_range(0, 3))
            0: h = '0;
            1: h = $urandom_range(0, 32'hFFFF);
            2: h = $urandom;
            default: h = $urandom_range(0, 32'h3F_FFFF);
          endcase
          case ($urandom_range(0, 3))
            0: s = 32'd0;
            1: s = 32'd31;
            2: s = 32'd12;
            default: s = $urandom_range(0, 31);
          endcase
          case ($urandom_range(0, 3))
            0: c = 32'd16;
            1: c = $urandom_range(17, 31);
            default: c = $urandom_range(1, 16);
          endcase
        end
      endcase
      write_reg(sat_pkg::REG_HEADER_SIZE, h);
      write_reg(sat_pkg::REG_ALIGN_SHIFT, s);
      write_reg(sat_pkg::REG_SECTION_COUNT, c);
      phases_run++;
      counted = 0;
      while (counted < PHASE_WORDS) begin
        r = $urandom_range(0, 99);
        if (r < 14) begin
          send_word(random_load(sat_pkg::EIDX_W'($urandom)));
          counted++;
        end else if (r < 17) begin
          send_word(make_word(OP_UNUSED, sat_pkg::EIDX_W'($urandom), $urandom, $urandom,
                              $urandom, $urandom));
        end else begin
          op = (r < 59) ? sat_pkg::OP_V2F : sat_pkg::OP_F2V;
          send_word(lookup_word(op, pick_address(op)));
          counted++;
        end
      end
    end
  endtask

  // Main sequence
  initial begin
    errors = 0;
    mismatches = 0;
    loads_sent = 0;
    lookups_sent = 0;
    hits_seen = 0;
    passes_seen = 0;
    phases_run = 0;
    burst_left = 0;
    hdr_size_q = '0;
    align_q = sat_pkg::ALIGN_SHIFT_RST;
    count_q = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      sect_base_mem[sat_pkg::EIDX_W'(i)] = '0;
      sect_size_mem[sat_pkg::EIDX_W'(i)] = '0;
      sect_off_mem[sat_pkg::EIDX_W'(i)]  = '0;
    end
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = '0;
    in_ch.entry_index = '0;
    in_ch.virt_base = '0;
    in_ch.raw_size = '0;
    in_ch.raw_offset = '0;
    in_ch.address = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    test_load_table();
    test_header_passthrough();
    test_forward_lookup();
    test_reverse_lookup();
    test_alignment_rounding();
    test_unused_opcode();
    test_random_table();
    test_random_phases();
    drain();

    if (pending_xlats.size() != 0) errors++;
    $display("covered %0d table loads and %0d lookups over %0d random settings",
             loads_sent, lookups_sent, phases_run);
    $display("lookups: %0d section hits, %0d header pass-throughs, %0d misses",
             hits_seen, passes_seen, lookups_sent - hits_seen - passes_seen);
    if (errors == 0) begin
      $display("section_address_translator: match");
    end else begin
      $display("section_address_translator: mismatch");
    end
    $finish;
  end

endmodule
